// File: hdl/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
// Widths of the request, response and configuration fields, request and status codes.
// No dependencies; compile first.
package bpa_pkg;

  // Map geometry
  localparam int MAP_WORDS_DEF = 32;
  localparam int WORD_W        = 32;
  localparam int BIT_W         = 5;

  // Field widths
  localparam int OP_W      = 2;
  localparam int PAGE_W    = 10;
  localparam int STATUS_W  = 2;
  localparam int CNT_W     = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FREE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 1'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] FIRST_FREE_RST = 11'd1;
  localparam logic [CFG_W-1:0] PAGE_COUNT_RST = 11'd1024;

  // Request kinds
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REBUILD = 2'd2
  } op_t;

  // Response status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

endpackage

// File: hdl/bpa_if.sv
// Valid/ready channel interfaces of the bitmap page allocator: request and response.
// Depends on bpa_pkg for field widths.
interface bpa_req_if;
  import bpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [PAGE_W-1:0] page;

  modport source (output valid, output op, output page, input ready);
  modport sink   (input valid, input op, input page, output ready);
endinterface

interface bpa_rsp_if;
  import bpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [PAGE_W-1:0]   granted_page;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    free_pages;

  modport source (output valid, output granted_page, output status, output free_pages,
                  input ready);
  modport sink   (input valid, input granted_page, input status, input free_pages,
                  output ready);
endinterface

// File: hdl/bitmap_page_allocator_top.sv
// Top level of the bitmap page allocator: request sequencer around the bitmap memory.
// Depends on bpa_pkg, bpa_if, bpa_map_ram, bpa_low_bit and bpa_fill_mask.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid/ready   | op, page
//   rsp     | out | valid/ready   | granted_page, status, free_pages
//   cfg     | in  | cfg_wr only   | cfg_idx, cfg_wdata
//
// Free: read the word, set the page's bit, push the result. Allocate: scan words from the
// rotating pointer, skipping the empty ones (0 to MAP_WORDS-1 of them), through the single
// memory read port read once per word. Allocate with no free page and the unused code go
// straight to the push. Rebuild: one memory write per word, then the push.
// After reset a clearing pass writes every word, with req.ready low.
// A result waits in the output register; the next request is taken meanwhile and
// holds at its end until the output register frees.
module bitmap_page_allocator_top #(
  parameter int MAP_WORDS = bpa_pkg::MAP_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  bpa_req_if.sink                       req,
  bpa_rsp_if.source                     rsp,
  input  logic                          cfg_wr,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [bpa_pkg::CFG_W-1:0]     cfg_wdata
);
  import bpa_pkg::*;

  localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW        = WW + BIT_W;
  localparam int MAP_PAGES = MAP_WORDS * WORD_W;
  localparam int AW        = (PW + 1 > CFG_W) ? PW + 1 : CFG_W;

  localparam logic [WW-1:0] LAST_WORD = WW'(MAP_WORDS - 1);
  localparam logic [AW-1:0] PAGES_A   = AW'(MAP_PAGES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_FILL,
    S_PUSH
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  first_free;
  logic [CFG_W-1:0]  page_count;
  logic [CNT_W-1:0]  free_total;
  logic [WW-1:0]     scan_word;
  logic [WW-1:0]     scan_ptr;
  logic [WW-1:0]     scan_cnt;
  logic [WW-1:0]     fill_idx;
  logic [PAGE_W-1:0] req_page;
  logic [PAGE_W-1:0] res_page;
  status_t           res_status;
  logic              out_valid;
  logic [PAGE_W-1:0] out_page;
  status_t           out_status;
  logic [CNT_W-1:0]  out_free;

  logic              take;
  logic              out_free_slot;
  logic [WW-1:0]     ptr_next;
  logic [AW-1:0]     limit;
  logic [AW-1:0]     first_a;
  logic [CNT_W-1:0]  rebuild_total;
  logic [WORD_W-1:0] fill_word;
  logic [BIT_W-1:0]  low_idx;
  logic [WORD_W-1:0] free_mask;
  logic              free_oob;

  logic              wr_en;
  logic [WW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;

  // Handshake
  assign req.ready        = (state == S_IDLE);
  assign take             = req.valid && req.ready;
  assign out_free_slot    = !out_valid || rsp.ready;
  assign rsp.valid        = out_valid;
  assign rsp.granted_page = out_page;
  assign rsp.status       = out_status;
  assign rsp.free_pages   = out_free;

  // Page limit and rebuild count
  assign first_a       = AW'(first_free);
  assign limit         = (AW'(page_count) < PAGES_A) ? AW'(page_count) : PAGES_A;
  assign rebuild_total = (limit > first_a) ? CNT_W'(limit - first_a) : '0;

  // Free request decode
  assign free_mask = WORD_W'(1) << req_page[BIT_W-1:0];
  assign free_oob  = AW'(req_page) >= limit;

  // Wrap the scan pointer
  assign ptr_next = (scan_ptr == LAST_WORD) ? '0 : scan_ptr + WW'(1);

  bpa_low_bit u_low_bit (
    .word (rd_data),
    .idx  (low_idx)
  );

  bpa_fill_mask #(
    .AW (AW)
  ) u_fill_mask (
    .base  (AW'({fill_idx, {BIT_W{1'b0}}})),
    .first (first_a),
    .limit (limit),
    .mask  (fill_word)
  );

  bpa_map_ram #(
    .DEPTH  (MAP_WORDS),
    .ADDR_W (WW)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Select the memory read address
  always_comb begin
    unique case (state)
      S_IDLE: begin
        if (op_t'(req.op) == OP_FREE) begin
          rd_addr = WW'(req.page >> BIT_W);
        end else begin
          rd_addr = scan_word;
        end
      end
      S_SCAN:  rd_addr = ptr_next;
      default: rd_addr = scan_word;
    endcase
  end

  // Select the memory write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_idx;
    wr_data = fill_word;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      S_FILL: begin
        wr_en = 1'b1;
      end
      S_SCAN: begin
        wr_en   = (rd_data != '0);
        wr_addr = scan_ptr;
        wr_data = rd_data & ~(WORD_W'(1) << low_idx);
      end
      S_FREE: begin
        wr_en   = !free_oob && ((rd_data & free_mask) == '0);
        wr_addr = WW'(req_page >> BIT_W);
        wr_data = rd_data | free_mask;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      first_free <= FIRST_FREE_RST;
      page_count <= PAGE_COUNT_RST;
      free_total <= '0;
      scan_word  <= '0;
      fill_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_FIRST_FREE: first_free <= cfg_wdata;
          REG_PAGE_COUNT: page_count <= cfg_wdata;
          default: ;
        endcase
      end

      // Drop a transferred result unless a new one takes its place
      if (out_valid && rsp.ready && (state != S_PUSH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          fill_idx <= fill_idx + WW'(1);
          if (fill_idx == LAST_WORD) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (take) begin
            req_page   <= req.page;
            res_page   <= '0;
            res_status <= ((op_t'(req.op) == OP_ALLOC) && (free_total == '0)) ?
                          ST_NO_FREE : ST_OK;
            unique case (op_t'(req.op))
              OP_ALLOC: begin
                if (free_total == '0) begin
                  state <= S_PUSH;
                end else begin
                  scan_ptr <= scan_word;
                  scan_cnt <= '0;
                  state    <= S_SCAN;
                end
              end
              OP_FREE: state <= S_FREE;
              OP_REBUILD: begin
                free_total <= rebuild_total;
                scan_word  <= '0;
                fill_idx   <= '0;
                state      <= S_FILL;
              end
              default: state <= S_PUSH;
            endcase
          end
        end

        S_SCAN: begin
          if (rd_data != '0) begin
            free_total <= free_total - CNT_W'(1);
            scan_word  <= scan_ptr;
            res_page   <= PAGE_W'({scan_ptr, low_idx});
            state      <= S_PUSH;
          end else if (scan_cnt == LAST_WORD) begin
            res_status <= ST_NO_FREE;
            state      <= S_PUSH;
          end else begin
            scan_ptr <= ptr_next;
            scan_cnt <= scan_cnt + WW'(1);
          end
        end

        S_FREE: begin
          if (free_oob) begin
            res_status <= ST_RANGE;
          end else if ((rd_data & free_mask) == '0) begin
            free_total <= free_total + CNT_W'(1);
          end
          state <= S_PUSH;
        end

        S_FILL: begin
          fill_idx <= fill_idx + WW'(1);
          if (fill_idx == LAST_WORD) begin
            state <= S_PUSH;
          end
        end

        S_PUSH: begin
          if (out_free_slot) begin
            out_valid  <= 1'b1;
            out_page   <= res_page;
            out_status <= res_status;
            out_free   <= free_total;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/bpa_map_ram.sv
// Free-page bitmap storage: one write port, one read port, registered read data.
// Depends on bpa_pkg for the word width.
module bpa_map_ram #(
  parameter int DEPTH  = bpa_pkg::MAP_WORDS_DEF,
  parameter int ADDR_W = 5
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [bpa_pkg::WORD_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [bpa_pkg::WORD_W-1:0] rd_data
);
  import bpa_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/bpa_low_bit.sv
// Lowest set bit of one bitmap word, found by halving in five steps.
// Depends on bpa_pkg for word and bit index widths.
module bpa_low_bit (
  input  logic [bpa_pkg::WORD_W-1:0] word,
  output logic [bpa_pkg::BIT_W-1:0]  idx
);
  import bpa_pkg::*;

  // Test the low half, step past it when empty
  always_comb begin
    logic [WORD_W-1:0] v;
    v   = word;
    idx = '0;
    for (int lvl = BIT_W - 1; lvl >= 0; lvl--) begin
      if ((v & ((WORD_W'(1) << (1 << lvl)) - WORD_W'(1))) == '0) begin
        idx[lvl] = 1'b1;
        v        = v >> (1 << lvl);
      end
    end
  end

endmodule

// File: hdl/bpa_fill_mask.sv
// Rebuild mask of one bitmap word: bits whose page lies in [first, limit).
// Depends on bpa_pkg for the word width.
module bpa_fill_mask #(
  parameter int AW = 11
) (
  input  logic [AW-1:0]              base,
  input  logic [AW-1:0]              first,
  input  logic [AW-1:0]              limit,
  output logic [bpa_pkg::WORD_W-1:0] mask
);
  import bpa_pkg::*;

  // Offset of a bound inside the word, clipped to 0..32
  function automatic logic [BIT_W:0] clip(input logic [AW-1:0] bound,
                                          input logic [AW-1:0] start);
    logic [AW-1:0] d;
    d = bound - start;
    if (bound <= start) begin
      return '0;
    end else if (d >= AW'(WORD_W)) begin
      return (BIT_W + 1)'(WORD_W);
    end else begin
      return d[BIT_W:0];
    end
  endfunction

  // Ones below the given offset
  function automatic logic [WORD_W-1:0] low_ones(input logic [BIT_W:0] n);
    if (n[BIT_W]) begin
      return '1;
    end else begin
      return (WORD_W'(1) << n[BIT_W-1:0]) - WORD_W'(1);
    end
  endfunction

  logic [BIT_W:0] lo;
  logic [BIT_W:0] hi;

  assign lo   = clip(first, base);
  assign hi   = clip(limit, base);
  assign mask = low_ones(hi) & ~low_ones(lo);

endmodule
